/* hw/rtl/mono_framebuffer_draw_engine_macros.svh */
// Assertion helpers for the draw engine.
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_MACROS_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_MACROS_SVH
// Check that an antecedent implies a consequent in the same cycle.
`define MFB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check that an antecedent implies a consequent in the next cycle.
`define MFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* hw/rtl/mfb_pkg.sv */
package mfb_pkg;
    localparam int DEF_PANEL_WIDTH  = 128;
    localparam int DEF_PANEL_HEIGHT = 64;
    localparam int ROWS_PER_PAGE    = 8;

    localparam logic [2:0] CMD_CLEAR = 3'd0;
    localparam logic [2:0] CMD_PIXEL = 3'd1;
    localparam logic [2:0] CMD_HLINE = 3'd2;
    localparam logic [2:0] CMD_VLINE = 3'd3;
    localparam logic [2:0] CMD_RECT  = 3'd4;
    localparam logic [2:0] CMD_FILL  = 3'd5;
    localparam logic [2:0] CMD_READ  = 3'd6;

    // One box job handed from the sequencer to the box walker.
    typedef struct packed {
        logic signed [11:0] x;
        logic signed [11:0] y;
        logic        [10:0] w;
        logic        [10:0] h;
        logic               on;
    } box_t;
endpackage

/* hw/rtl/mfb_box_walker.sv */
// Walks a clipped box one (page, column) byte per step with a read-modify-write
// of the store. Also runs the clearing sweep and single byte reads.
module mfb_box_walker #(
    parameter int PANEL_WIDTH  = mfb_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = mfb_pkg::DEF_PANEL_HEIGHT
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            box_start,
    input  mfb_pkg::box_t   box,
    input  logic            clr_start,
    input  logic            rd_start,
    input  logic [$clog2(PANEL_WIDTH)-1:0]                        rd_col,
    input  logic [$clog2((PANEL_HEIGHT+7)/8)-1+((PANEL_HEIGHT+7)/8==1):0] rd_page,
    output logic            busy,
    output logic            rd_done,
    output logic [7:0]      rd_data
);
    localparam int PAGES = (PANEL_HEIGHT + 7) / 8;
    localparam int CW    = $clog2(PANEL_WIDTH);
    localparam int PW    = $clog2(PAGES) + (PAGES == 1);
    localparam int DEPTH = PANEL_WIDTH * PAGES;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_READ  = 6'b000010,
        ST_WRITE = 6'b000100,
        ST_CLEAR = 6'b001000,
        ST_RDOUT = 6'b010000,
        ST_RDMEM = 6'b100000
    } wstate_t;

    wstate_t state_reg, state_next;
    logic [7:0] mem [DEPTH];
    logic [7:0] q_reg;
    logic [CW-1:0] col_reg, col_lo_reg, col_hi_reg;
    logic [PW-1:0] page_reg, page_hi_reg;
    logic [7:0] mask_lo_reg, mask_hi_reg;
    logic [PW-1:0] page_lo_reg;
    logic on_reg;
    logic [AW-1:0] clr_addr_reg;

    // Clip bounds, computed once at start.
    logic signed [12:0] x0, y0, x1, y1;
    logic [6:0] r0, r1;
    always_comb begin
        x0 = (box.x < 0) ? 13'sd0 : 13'(box.x);
        y0 = (box.y < 0) ? 13'sd0 : 13'(box.y);
        x1 = 13'(box.x) + $signed({2'b0, box.w});
        y1 = 13'(box.y) + $signed({2'b0, box.h});
        if (x1 > 13'(PANEL_WIDTH))  x1 = 13'(PANEL_WIDTH);
        if (y1 > 13'(PANEL_HEIGHT)) y1 = 13'(PANEL_HEIGHT);
        r0 = 7'(y0);
        r1 = 7'(y1 - 13'sd1);
    end
    wire box_empty = (x0 >= x1) || (y0 >= y1);

    // Row mask within the current page.
    logic [7:0] mask;
    always_comb begin
        mask = 8'hFF;
        if (page_reg == page_lo_reg) mask = mask & mask_lo_reg;
        if (page_reg == page_hi_reg) mask = mask & mask_hi_reg;
    end

    wire [AW-1:0] addr = AW'(page_reg * PANEL_WIDTH + col_reg);
    wire last_col = (col_reg == col_hi_reg);
    wire last_pg  = (page_reg == page_hi_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_addr_reg <= clr_addr_reg + 1'b1;
            else if (clr_start)        clr_addr_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR) mem[clr_addr_reg] <= 8'h00;
        else if (state_reg == ST_WRITE)
            mem[addr] <= on_reg ? (q_reg | mask) : (q_reg & ~mask);
        q_reg <= mem[addr];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && box_start) begin
            col_reg     <= CW'(x0);
            col_lo_reg  <= CW'(x0);
            col_hi_reg  <= CW'(x1 - 13'sd1);
            page_reg    <= PW'(r0 >> 3);
            page_lo_reg <= PW'(r0 >> 3);
            page_hi_reg <= PW'(r1 >> 3);
            mask_lo_reg <= 8'hFF << r0[2:0];
            mask_hi_reg <= 8'hFF >> (3'd7 - r1[2:0]);
            on_reg      <= box.on;
        end else if (state_reg == ST_IDLE && rd_start) begin
            col_reg  <= rd_col;
            page_reg <= rd_page;
        end else if (state_reg == ST_WRITE) begin
            if (last_col) begin
                col_reg  <= col_lo_reg;
                page_reg <= page_reg + 1'b1;
            end else begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (clr_start) state_next = ST_CLEAR;
                else if (box_start && !box_empty) state_next = ST_READ;
                else if (rd_start) state_next = ST_RDMEM;
            end
            ST_READ:  state_next = ST_WRITE;
            ST_WRITE: state_next = (last_col && last_pg) ? ST_IDLE : ST_READ;
            ST_CLEAR: if (clr_addr_reg == AW'(DEPTH - 1)) state_next = ST_IDLE;
            // Address settles this cycle; the byte lands in q_reg at the edge.
            ST_RDMEM: state_next = ST_RDOUT;
            ST_RDOUT: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    assign busy    = (state_reg != ST_IDLE);
    assign rd_done = (state_reg == ST_RDOUT);
    assign rd_data = q_reg;
endmodule

/* hw/rtl/mfb_sequencer.sv */
`include "mono_framebuffer_draw_engine_macros.svh"
// Splits each drawing command into box jobs for the walker, starts clears and reads, and holds the read result.
module mfb_sequencer #(
    parameter int PANEL_WIDTH  = mfb_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = mfb_pkg::DEF_PANEL_HEIGHT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_command,
    input  logic signed [9:0]   s_pos_x,
    input  logic signed [9:0]   s_pos_y,
    input  logic [8:0]          s_span_w,
    input  logic [8:0]          s_span_h,
    input  logic                s_set_bits,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_column_byte,
    output logic [2:0]          m_page_index,
    output logic [6:0]          m_column_index
);
    localparam int PAGES = (PANEL_HEIGHT + 7) / 8;
    localparam int CW    = $clog2(PANEL_WIDTH);
    localparam int PW    = $clog2(PAGES) + (PAGES == 1);

    typedef enum logic [3:0] {
        SQ_IDLE = 4'b0001,
        SQ_ISSUE = 4'b0010,
        SQ_WAIT = 4'b0100,
        SQ_OUT  = 4'b1000
    } sstate_t;

    sstate_t state_reg, state_next;
    logic [1:0] part_reg, nparts_reg;
    logic [2:0] cmd_reg;
    logic signed [9:0] x_reg, y_reg;
    logic [8:0] w_reg, h_reg;
    logic on_reg;
    logic [7:0] byte_reg;
    logic busy, rd_done, started_reg;
    logic [7:0] rd_data;
    mfb_pkg::box_t box;

    wire acc = s_valid && s_ready;
    wire rd_on = (x_reg >= 0) && (x_reg < 10'sd0 + 11'(PANEL_WIDTH))
              && (y_reg >= 0) && (y_reg < 10'sd0 + 11'(PANEL_HEIGHT));

    always_comb begin
        box.x = 12'(x_reg); box.y = 12'(y_reg);
        box.w = 11'd1; box.h = 11'd1; box.on = on_reg;
        case (cmd_reg)
            mfb_pkg::CMD_HLINE: box.w = 11'(w_reg);
            mfb_pkg::CMD_VLINE: box.h = 11'(h_reg);
            mfb_pkg::CMD_FILL: begin box.w = 11'(w_reg); box.h = 11'(h_reg); end
            mfb_pkg::CMD_RECT: begin
                case (part_reg)
                    2'd0: box.w = 11'(w_reg);
                    2'd1: begin
                        box.w = 11'(w_reg);
                        box.y = 12'(y_reg) + 12'(h_reg) - 12'sd1;
                    end
                    2'd2: box.h = 11'(h_reg);
                    default: begin
                        box.h = 11'(h_reg);
                        box.x = 12'(x_reg) + 12'(w_reg) - 12'sd1;
                    end
                endcase
            end
            default: ;
        endcase
    end

    wire is_box = (cmd_reg inside {mfb_pkg::CMD_PIXEL, mfb_pkg::CMD_HLINE,
                   mfb_pkg::CMD_VLINE, mfb_pkg::CMD_RECT, mfb_pkg::CMD_FILL});
    wire issue = (state_reg == SQ_ISSUE) && !busy;

    mfb_box_walker #(.PANEL_WIDTH(PANEL_WIDTH), .PANEL_HEIGHT(PANEL_HEIGHT)) u_walk (
        .aclk(aclk), .aresetn(aresetn),
        .box_start(issue && is_box), .box(box),
        .clr_start(issue && cmd_reg == mfb_pkg::CMD_CLEAR),
        .rd_start(issue && cmd_reg == mfb_pkg::CMD_READ && rd_on),
        .rd_col(CW'(x_reg)), .rd_page(PW'(y_reg >>> 3)),
        .busy(busy), .rd_done(rd_done), .rd_data(rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SQ_IDLE;
            part_reg    <= '0;
            started_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (acc) part_reg <= '0;
            else if (issue) part_reg <= part_reg + 1'b1;
            started_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            cmd_reg <= s_command; x_reg <= s_pos_x; y_reg <= s_pos_y;
            w_reg <= s_span_w; h_reg <= s_span_h; on_reg <= s_set_bits;
            nparts_reg <= (s_command == mfb_pkg::CMD_RECT) ? 2'd3 : 2'd0;
        end
        if (rd_done) byte_reg <= rd_data;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SQ_IDLE: if (acc) state_next = SQ_ISSUE;
            SQ_ISSUE: if (issue) begin
                if (part_reg == nparts_reg) state_next = SQ_WAIT;
            end
            SQ_WAIT: begin
                if (rd_done) state_next = SQ_OUT;
                else if (!busy && !started_reg) state_next = SQ_IDLE;
            end
            SQ_OUT: if (m_ready) state_next = SQ_IDLE;
            default: state_next = SQ_IDLE;
        endcase
    end

    assign s_ready        = (state_reg == SQ_IDLE);
    assign m_valid        = (state_reg == SQ_OUT);
    assign m_column_byte  = byte_reg;
    assign m_page_index   = 3'(y_reg >>> 3);
    assign m_column_index = 7'(x_reg);

    `MFB_ASSERT_IMP(a_no_overlap, aclk, aresetn, m_valid, !s_ready, "result and input overlap")
    `MFB_ASSERT_NEXT(a_rd_out, aclk, aresetn, rd_done, m_valid, "read byte not presented")
    `MFB_ASSERT_IMP(a_out_read, aclk, aresetn, m_valid, cmd_reg == mfb_pkg::CMD_READ, "result for non-read command")
endmodule

/* hw/rtl/mono_framebuffer_draw_engine.sv */
// Channel | Direction | Fields
// s_      | in        | command, pos_x, pos_y, span_w, span_h, set_bits
// m_      | out       | column_byte, page_index, column_index (read command only)
// A box job reads each touched byte and then writes it back;
//   a rectangle outline runs four jobs.
// Clear sweeps the store one byte a cycle over all PANEL_WIDTH*ceil(PANEL_HEIGHT/8) bytes.
// Reset runs the same clear sweep; a command accepted meanwhile waits until it ends.
// The single store port sets the rate; s_ready is low while a command runs
//   and while a read result waits for m_ready.
module mono_framebuffer_draw_engine #(
    parameter int PANEL_WIDTH  = mfb_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = mfb_pkg::DEF_PANEL_HEIGHT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_command,
    input  logic signed [9:0] s_pos_x,
    input  logic signed [9:0] s_pos_y,
    input  logic [8:0]        s_span_w,
    input  logic [8:0]        s_span_h,
    input  logic              s_set_bits,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_column_byte,
    output logic [2:0]        m_page_index,
    output logic [6:0]        m_column_index
);
    // The sequencer holds each command until the walker is idle, so the
    // clear sweep after reset needs no extra gating here.
    mfb_sequencer #(.PANEL_WIDTH(PANEL_WIDTH), .PANEL_HEIGHT(PANEL_HEIGHT)) u_seq (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_command(s_command), .s_pos_x(s_pos_x), .s_pos_y(s_pos_y),
        .s_span_w(s_span_w), .s_span_h(s_span_h), .s_set_bits(s_set_bits),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_column_byte(m_column_byte), .m_page_index(m_page_index),
        .m_column_index(m_column_index)
    );
endmodule
